### design/erbp_pkg.sv
// ----------------------------------------------------------------------------
// erbp_pkg
// Shared constants, register codes and beat types for the edge-replicating
// border padder.
// ----------------------------------------------------------------------------
package erbp_pkg;

    // Default size limits handed to the top level parameters
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_MAX_BORDER = 3;

    // Fixed field widths
    localparam int ADDR_W     = 23;
    localparam int PIX_W      = 8;
    localparam int SIZE_REG_W = 12;
    localparam int BW_W       = 2;
    localparam int CH_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT = 3'd4;

    // Register reset values
    localparam logic [SIZE_REG_W-1:0] RST_IMAGE_WIDTH    = 12'd640;
    localparam logic [SIZE_REG_W-1:0] RST_IMAGE_HEIGHT   = 12'd480;
    localparam logic [BW_W-1:0]       RST_BORDER_WIDTH   = 2'd2;
    localparam logic                  RST_GRAY_MODE      = 1'b1;
    localparam logic [CH_W-1:0]       RST_CHANNEL_SELECT = 2'd0;

    // Channel codes
    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    // Divide by 3 as multiply by 683 / 2^11, exact for sums up to 765
    localparam logic [9:0] GRAY_RECIP = 10'd683;
    localparam int         GRAY_SHIFT = 11;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic top;
        logic bot;
        logic lft;
        logic rgt;
    } edge_t;

    // One classified pixel
    typedef struct packed {
        logic [PIX_W-1:0]  val;
        logic [ADDR_W-1:0] cb;    // centre row base (r+B)*nw
        logic [ADDR_W-1:0] colb;  // centre column c+B
        edge_t             edges;
    } qent_t;

    // Padded frame geometry, registered from the config registers
    typedef struct packed {
        logic [ADDR_W-1:0] nw;    // padded width
        logic [ADDR_W-1:0] bnw;   // B * nw
        logic [BW_W-1:0]   b;     // effective border
    } geom_t;

endpackage

### design/erbp_src_if.sv
// ----------------------------------------------------------------------------
// erbp_src_if
// Source pixel channel: valid/ready plus one RGB pixel per beat.
// ----------------------------------------------------------------------------
interface erbp_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### design/erbp_dst_if.sv
// ----------------------------------------------------------------------------
// erbp_dst_if
// Destination write channel: one padded-frame byte write per beat.
// ----------------------------------------------------------------------------
interface erbp_dst_if;
    logic        valid;
    logic        ready;
    logic [22:0] dest_address;
    logic [7:0]  pixel_value;
    logic        last_write;

    modport source (output valid, output dest_address, output pixel_value,
                    output last_write, input ready);
    modport sink   (input valid, input dest_address, input pixel_value,
                    input last_write, output ready);
endinterface

### design/erbp_front.sv
// ----------------------------------------------------------------------------
// erbp_front
// Accepts source pixels, reduces them to one byte, tracks raster position,
// classifies edges and computes the centre row base for the queue.
// ----------------------------------------------------------------------------
module erbp_front
    import erbp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_BORDER = DEF_MAX_BORDER,
    localparam int SW  = $clog2(MAX_WIDTH + 1),
    localparam int SH  = $clog2(MAX_HEIGHT + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    erbp_src_if.sink        src,
    input  logic [SW-1:0]   w,
    input  logic [SH-1:0]   h,
    input  logic [BW_W-1:0] border,
    input  logic            gray_mode,
    input  logic [CH_W-1:0] channel_select,
    input  logic [ADDR_W-1:0] nw,
    input  logic            q_full,
    output logic            q_push,
    output qent_t           q_wdata
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RBW = (MAX_HEIGHT + MAX_BORDER > 1) ? $clog2(MAX_HEIGHT + MAX_BORDER) : 1;
    localparam int PW  = RBW + ADDR_W;

    logic [CW-1:0]     col_reg, col_next, col_cur;
    logic [RW-1:0]     row_reg, row_next, row_cur;
    logic              col_last, row_last, accept;
    logic [9:0]        sum;
    logic [19:0]       prod;
    logic [PIX_W-1:0]  val_c;
    logic              a_valid_reg, a_valid_next;
    logic [PIX_W-1:0]  a_val_reg;
    logic [RBW-1:0]    a_rowb_reg;
    logic [ADDR_W-1:0] a_colb_reg;
    edge_t             a_edge_reg, edge_c;
    logic [PW-1:0]     cb_prod;

    // Raster position; stale counters past the frame restart at zero
    assign col_cur  = (SW'(col_reg) < w) ? col_reg : '0;
    assign row_cur  = (SH'(row_reg) < h) ? row_reg : '0;
    assign col_last = (SW'(col_cur) == w - SW'(1));
    assign row_last = (SH'(row_cur) == h - SH'(1));

    assign edge_c.top = (row_cur == '0);
    assign edge_c.bot = row_last;
    assign edge_c.lft = (col_cur == '0);
    assign edge_c.rgt = col_last;

    assign src.ready = !a_valid_reg || !q_full;
    assign accept    = src.valid && src.ready;
    assign q_push    = a_valid_reg && !q_full;

    // Byte reduction
    assign sum  = 10'(src.red) + 10'(src.green) + 10'(src.blue);
    assign prod = 20'(sum) * 20'(GRAY_RECIP);

    always_comb
    begin
        if (gray_mode)
        begin
            val_c = prod[GRAY_SHIFT +: PIX_W];
        end
        else
        begin
            unique case (channel_select)
                CH_RED:   val_c = src.red;
                CH_GREEN: val_c = src.green;
                default:  val_c = src.blue;
            endcase
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_cur + RW'(1);
            end
            else
            begin
                col_next = col_cur + CW'(1);
                row_next = row_cur;
            end
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_val_reg  <= val_c;
            a_rowb_reg <= RBW'(row_cur) + RBW'(border);
            a_colb_reg <= ADDR_W'(col_cur) + ADDR_W'(border);
            a_edge_reg <= edge_c;
        end
    end

    // Centre row base; the queue entry registers the product
    assign cb_prod = PW'(a_rowb_reg) * PW'(nw);

    assign q_wdata.val   = a_val_reg;
    assign q_wdata.cb    = cb_prod[ADDR_W-1:0];
    assign q_wdata.colb  = a_colb_reg;
    assign q_wdata.edges = a_edge_reg;

endmodule

### design/erbp_fifo.sv
// ----------------------------------------------------------------------------
// erbp_fifo
// Short queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module erbp_fifo
    import erbp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t wdata,
    output logic  full,
    output logic  rd_valid,
    output qent_t rdata,
    input  logic  pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    qent_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rdata    = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### design/erbp_back.sv
// ----------------------------------------------------------------------------
// erbp_back
// Write sequencer: emits the centre write, then the border strips and the
// corner squares of edge pixels, one write per beat.
// ----------------------------------------------------------------------------
module erbp_back
    import erbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  qent_t      q_data,
    output logic       q_pop,
    input  geom_t      geom,
    erbp_dst_if.source dst
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_TB     = 2'd1;
    localparam logic [1:0] ST_LR     = 2'd2;
    localparam logic [1:0] ST_CORNER = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [PIX_W-1:0]  out_val_reg, out_val_next;
    logic              out_last_reg, out_last_next;

    logic [PIX_W-1:0]  val_reg, val_next;
    logic [ADDR_W-1:0] cb_reg, cb_next;
    logic [ADDR_W-1:0] colb_reg, colb_next;
    logic [ADDR_W-1:0] lower0_reg, lower0_next;
    logic [ADDR_W-1:0] upper_reg, upper_next;
    logic [ADDR_W-1:0] lower_reg, lower_next;
    logic [ADDR_W-1:0] cr_reg, cr_next;
    logic [BW_W-1:0]   i_reg, i_next, j_reg, j_next;
    logic [3:0]        mask_reg, mask_next;
    logic [1:0]        mtb_reg, mtb_next, mlr_reg, mlr_next;
    logic [3:0]        mc_reg, mc_next;

    logic              out_free, has_b, i_more, j_more, idx_more;
    logic [1:0]        h_mtb, h_mlr;
    logic [3:0]        h_mc, sel, rest;
    logic [1:0]        first_ph, after_ph, enter_ph;
    logic              do_enter;
    logic [ADDR_W-1:0] head_l0, enter_l0, row_term, col_term, emit_addr;

    assign out_free = !out_valid_reg || dst.ready;
    assign has_b    = (geom.b != '0);

    // Border write masks of the queue head
    assign h_mtb = has_b ? {q_data.edges.bot, q_data.edges.top} : 2'b00;
    assign h_mlr = has_b ? {q_data.edges.rgt, q_data.edges.lft} : 2'b00;
    // Corner order per (i,j): upper left, lower left, upper right, lower right
    assign h_mc  = has_b ? {q_data.edges.bot & q_data.edges.rgt,
                            q_data.edges.top & q_data.edges.rgt,
                            q_data.edges.bot & q_data.edges.lft,
                            q_data.edges.top & q_data.edges.lft} : 4'b0000;
    assign head_l0 = q_data.cb + geom.bnw;

    assign first_ph = (h_mtb != '0) ? ST_TB :
                      (h_mlr != '0) ? ST_LR :
                      (h_mc  != '0) ? ST_CORNER : ST_IDLE;

    always_comb
    begin
        unique case (state_reg)
            ST_TB:   after_ph = (mlr_reg != '0) ? ST_LR :
                                (mc_reg  != '0) ? ST_CORNER : ST_IDLE;
            ST_LR:   after_ph = (mc_reg != '0) ? ST_CORNER : ST_IDLE;
            default: after_ph = ST_IDLE;
        endcase
    end

    assign sel    = mask_reg & (~mask_reg + 4'd1);
    assign rest   = mask_reg & ~sel;
    assign i_more = ({1'b0, i_reg} + 3'd1) < {1'b0, geom.b};
    assign j_more = ({1'b0, j_reg} + 3'd1) < {1'b0, geom.b};

    always_comb
    begin
        unique case (state_reg)
            ST_TB:     idx_more = j_more;
            ST_LR:     idx_more = i_more;
            ST_CORNER: idx_more = j_more || i_more;
            default:   idx_more = 1'b0;
        endcase
    end

    // Address of the write at hand: one row term plus one column term
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                row_term = q_data.cb;
                col_term = q_data.colb;
            end
            ST_TB:
            begin
                row_term = sel[0] ? upper_reg : lower_reg;
                col_term = colb_reg;
            end
            ST_LR:
            begin
                row_term = cb_reg;
                col_term = sel[0] ? ADDR_W'(i_reg) : cr_reg;
            end
            default:
            begin
                row_term = (sel[0] || sel[2]) ? upper_reg : lower_reg;
                col_term = (sel[0] || sel[1]) ? ADDR_W'(i_reg) : cr_reg;
            end
        endcase
    end

    assign emit_addr = row_term + col_term;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        val_next       = val_reg;
        cb_next        = cb_reg;
        colb_next      = colb_reg;
        lower0_next    = lower0_reg;
        upper_next     = upper_reg;
        lower_next     = lower_reg;
        cr_next        = cr_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        mask_next      = mask_reg;
        mtb_next       = mtb_reg;
        mlr_next       = mlr_reg;
        mc_next        = mc_reg;
        q_pop          = 1'b0;
        do_enter       = 1'b0;
        enter_ph       = ST_IDLE;
        enter_l0       = lower0_reg;

        if (out_valid_reg && dst.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    out_addr_next  = emit_addr;
                    out_val_next   = q_data.val;
                    out_last_next  = (first_ph == ST_IDLE);
                    val_next       = q_data.val;
                    cb_next        = q_data.cb;
                    colb_next      = q_data.colb;
                    lower0_next    = head_l0;
                    mtb_next       = h_mtb;
                    mlr_next       = h_mlr;
                    mc_next        = h_mc;
                    do_enter       = 1'b1;
                    enter_ph       = first_ph;
                    enter_l0       = head_l0;
                end
            end
            default:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = emit_addr;
                    out_val_next   = val_reg;
                    out_last_next  = 1'b0;
                    if (rest != '0)
                    begin
                        mask_next = rest;
                    end
                    else if (idx_more)
                    begin
                        if (state_reg == ST_LR)
                        begin
                            i_next    = i_reg + BW_W'(1);
                            cr_next   = cr_reg - ADDR_W'(1);
                            mask_next = {2'b00, mlr_reg};
                        end
                        else if (j_more)
                        begin
                            // next border row in the strip or corner square
                            j_next     = j_reg + BW_W'(1);
                            upper_next = upper_reg + geom.nw;
                            lower_next = lower_reg - geom.nw;
                            mask_next  = (state_reg == ST_TB) ? {2'b00, mtb_reg} : mc_reg;
                        end
                        else
                        begin
                            // next corner column, rows restart
                            i_next     = i_reg + BW_W'(1);
                            j_next     = '0;
                            upper_next = '0;
                            lower_next = lower0_reg;
                            cr_next    = cr_reg - ADDR_W'(1);
                            mask_next  = mc_reg;
                        end
                    end
                    else
                    begin
                        out_last_next = (after_ph == ST_IDLE);
                        do_enter      = 1'b1;
                        enter_ph      = after_ph;
                    end
                end
            end
        endcase

        if (do_enter)
        begin
            state_next = enter_ph;
            i_next     = '0;
            j_next     = '0;
            upper_next = '0;
            lower_next = enter_l0;
            cr_next    = geom.nw - ADDR_W'(1);
            unique case (enter_ph)
                ST_TB:     mask_next = {2'b00, mtb_next};
                ST_LR:     mask_next = {2'b00, mlr_next};
                ST_CORNER: mask_next = mc_next;
                default:   mask_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_addr_reg <= out_addr_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        val_reg      <= val_next;
        cb_reg       <= cb_next;
        colb_reg     <= colb_next;
        lower0_reg   <= lower0_next;
        upper_reg    <= upper_next;
        lower_reg    <= lower_next;
        cr_reg       <= cr_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        mask_reg     <= mask_next;
        mtb_reg      <= mtb_next;
        mlr_reg      <= mlr_next;
        mc_reg       <= mc_next;
    end

    assign dst.valid        = out_valid_reg;
    assign dst.dest_address = out_addr_reg;
    assign dst.pixel_value  = out_val_reg;
    assign dst.last_write   = out_last_reg;

endmodule

### design/edge_replicate_border_pad.sv
// ----------------------------------------------------------------------------
// edge_replicate_border_pad
// Top level: config registers, front classifier, pixel queue and write
// sequencer of the clamp-to-edge border padder.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake          Beat
//  src       in    valid/ready        one RGB source pixel, raster order
//  dst       out   valid/ready        one padded-frame write, last_write on
//                                     the final write of a pixel
//  cfg       in    cfg_we             register write, index + data, no wait
//
//  Rate: an interior pixel takes a single write at the write sequencer, so
//  the stream runs at one pixel per cycle while dst does not stall. An edge
//  pixel takes one centre write plus B per top/bottom edge, B per left/right
//  edge and B*B per corner it lies on, so more when the frame is one pixel
//  wide or high. The sequencer emits one write per cycle while dst is ready.
//  A src beat reaches dst through the front stage, queue and output register.
//  Reset clears the raster counters, the queue and the sequencer, and loads
//  the register defaults 640 x 480, border 2, grayscale.
//  dst stalls back up through the output register, sequencer and queue;
//  src stays ready while the queue has room.
//
module edge_replicate_border_pad
    import erbp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_BORDER = DEF_MAX_BORDER
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    erbp_src_if.sink              src,
    erbp_dst_if.source            dst,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SW = $clog2(MAX_WIDTH + 1);
    localparam int SH = $clog2(MAX_HEIGHT + 1);

    // Config registers
    logic [SIZE_REG_W-1:0] image_width_reg;
    logic [SIZE_REG_W-1:0] image_height_reg;
    logic [BW_W-1:0]       border_width_reg;
    logic                  gray_mode_reg;
    logic [CH_W-1:0]       channel_select_reg;

    // Effective sizes: zero counts as one, oversize saturates
    logic [SW-1:0]     w;
    logic [SH-1:0]     h;
    logic [BW_W-1:0]   b;
    logic [ADDR_W-1:0] nw_c;
    logic [ADDR_W+BW_W-1:0] bnw_c;
    geom_t             geom_reg;

    // Queue wiring
    logic  q_full, q_push, q_valid, q_pop;
    qent_t q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= RST_IMAGE_WIDTH;
            image_height_reg   <= RST_IMAGE_HEIGHT;
            border_width_reg   <= RST_BORDER_WIDTH;
            gray_mode_reg      <= RST_GRAY_MODE;
            channel_select_reg <= RST_CHANNEL_SELECT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data[SIZE_REG_W-1:0];
                REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data[SIZE_REG_W-1:0];
                REG_BORDER_WIDTH:   border_width_reg   <= cfg_data[BW_W-1:0];
                REG_GRAY_MODE:      gray_mode_reg      <= cfg_data[0];
                REG_CHANNEL_SELECT: channel_select_reg <= cfg_data[CH_W-1:0];
                default:            ; // unknown index: ignored
            endcase
        end
    end

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w = SW'(1);
        end
        else if (int'(image_width_reg) > MAX_WIDTH)
        begin
            w = SW'(MAX_WIDTH);
        end
        else
        begin
            w = SW'(image_width_reg);
        end

        if (image_height_reg == '0)
        begin
            h = SH'(1);
        end
        else if (int'(image_height_reg) > MAX_HEIGHT)
        begin
            h = SH'(MAX_HEIGHT);
        end
        else
        begin
            h = SH'(image_height_reg);
        end

        b = (int'(border_width_reg) > MAX_BORDER) ? BW_W'(MAX_BORDER) : border_width_reg;
    end

    // Padded width and B*nw. Registered: the first pixel after a config
    // write needs them in the cycle after it is accepted at the earliest.
    assign nw_c  = ADDR_W'(w) + ADDR_W'({b, 1'b0});
    assign bnw_c = (ADDR_W + BW_W)'(nw_c) * (ADDR_W + BW_W)'(b);

    always_ff @(posedge clk)
    begin
        geom_reg.nw  <= nw_c;
        geom_reg.bnw <= bnw_c[ADDR_W-1:0];
        geom_reg.b   <= b;
    end

    erbp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_BORDER (MAX_BORDER)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .src            (src),
        .w              (w),
        .h              (h),
        .border         (b),
        .gray_mode      (gray_mode_reg),
        .channel_select (channel_select_reg),
        .nw             (geom_reg.nw),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_wdata        (q_wdata)
    );

    erbp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wdata    (q_wdata),
        .full     (q_full),
        .rd_valid (q_valid),
        .rdata    (q_rdata),
        .pop      (q_pop)
    );

    erbp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .geom    (geom_reg),
        .dst     (dst)
    );

endmodule

### design/erbp_checker.sv
// ----------------------------------------------------------------------------
// erbp_checker
// Port-level checks of the border padder, bound to the top level.
// ----------------------------------------------------------------------------
module erbp_checker
    import erbp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        src_valid,
    input logic        src_ready,
    input logic        dst_valid,
    input logic        dst_ready,
    input logic [22:0] dst_address,
    input logic [7:0]  dst_value,
    input logic        dst_last
);

    // front stage + queue + sequencer
    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 2;

    logic [3:0] inflight_reg;
    logic       src_beat, dst_done;

    assign src_beat = src_valid && src_ready;
    assign dst_done = dst_valid && dst_ready && dst_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 4'(src_beat) - 4'(dst_done);
        end
    end

    // a clock edge in reset leaves dst idle on the next edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !dst_valid)
        else $error("dst valid after a reset edge");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> inflight_reg != '0)
        else $error("write beat with no pixel outstanding");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 4'(MAX_INFLIGHT))
        else $error("too many pixels in flight");

    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid && $stable(dst_address)
                                    && $stable(dst_value) && $stable(dst_last))
        else $error("stalled write beat changed");

endmodule

bind edge_replicate_border_pad erbp_checker u_erbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .src_valid   (src.valid),
    .src_ready   (src.ready),
    .dst_valid   (dst.valid),
    .dst_ready   (dst.ready),
    .dst_address (dst.dest_address),
    .dst_value   (dst.pixel_value),
    .dst_last    (dst.last_write)
);
